// ===== rtl/icar_pkg.sv =====
// ----------------------------------------------------------------------------
// icar_pkg
// Shared types and constants of the I2C current average responder.
// ----------------------------------------------------------------------------
package icar_pkg;

  localparam int unsigned DefChannels   = 7;
  localparam int unsigned DefCountWidth = 32;
  localparam int unsigned SumWidth      = 64;
  localparam int unsigned AvgWidth      = 16;
  localparam int unsigned CurWidth      = 15;
  localparam int unsigned CurFields     = 7;

  localparam logic [7:0] CmdMagic       = 8'h01;
  localparam logic [7:0] CmdReadCurrent = 8'h02;
  localparam logic [7:0] MagicByte      = 8'had;
  localparam logic [4:0] PosMax         = 5'd31;

  typedef enum logic [1:0] {
    EvSample = 2'd0,
    EvAddr   = 2'd1,
    EvRx     = 2'd2,
    EvTx     = 2'd3
  } event_e;

  typedef enum logic [2:0] {
    StIdle,
    StAccRd,
    StAccWr,
    StDivRd,
    StDivRun,
    StDivWr,
    StTx,
    StOut
  } state_e;

  // Control between the top level and the divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/icar_divider.sv =====
// ----------------------------------------------------------------------------
// icar_divider
// Radix-2 restoring divider: a 64-bit sum over a count, one bit per cycle.
// ----------------------------------------------------------------------------
module icar_divider #(
  parameter int unsigned COUNT_WIDTH = icar_pkg::DefCountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  icar_pkg::div_req_t            req_i,
  input  logic [icar_pkg::SumWidth-1:0] dividend_i,
  input  logic [COUNT_WIDTH-1:0]        divisor_i,
  output icar_pkg::div_stat_t           stat_o,
  output logic [icar_pkg::AvgWidth-1:0] quotient_o
);
  import icar_pkg::*;

  localparam int unsigned CntW = $clog2(SumWidth + 1);

  logic [SumWidth-1:0]    quo_q, quo_d;
  logic [COUNT_WIDTH:0]   rem_q, rem_d;
  logic [COUNT_WIDTH-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d, done_q, done_d;
  logic [COUNT_WIDTH:0]   trial;

  // One shift-subtract step per cycle.
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[COUNT_WIDTH-1:0], quo_q[SumWidth-1]};
    if (req_i.start) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CntW'(SumWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial - {1'b0, dvs_q};
        quo_d = {quo_q[SumWidth-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[SumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // A zero count gives a zero average.
  assign quotient_o  = (dvs_q == '0) ? '0 : quo_q[AvgWidth-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== rtl/i2c_current_average_responder.sv =====
// ----------------------------------------------------------------------------
// i2c_current_average_responder
// Byte-level I2C slave side that averages channel currents on request.
// ----------------------------------------------------------------------------
// One request at a time. A sample passes through the accumulator memory
// channel by channel after it is accepted (read, then write back). A read
// address match with the read-current command runs each channel through the
// one-bit-per-cycle divider (start, 64 steps, done, write back), followed by
// the transmit step. A received byte or a write address match is finished in
// the cycle it is accepted. A transmit request, or a read address match
// without division, passes the transmit step, which skips masked-off channels
// one at a time, then the output step, which picks an average byte out of the
// memory before the byte is offered; the block then waits for the byte to be
// taken. Sums, counts and averages live in memories; they reset to zero
// through valid bits, one per channel and memory.
module i2c_current_average_responder #(
  parameter int unsigned CHANNELS    = icar_pkg::DefChannels,
  parameter int unsigned COUNT_WIDTH = icar_pkg::DefCountWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    event_kind_i,
  input  logic                          read_not_write_i,
  input  logic [7:0]                    rx_byte_i,
  input  logic [icar_pkg::CurWidth-1:0] current_0_i,
  input  logic [icar_pkg::CurWidth-1:0] current_1_i,
  input  logic [icar_pkg::CurWidth-1:0] current_2_i,
  input  logic [icar_pkg::CurWidth-1:0] current_3_i,
  input  logic [icar_pkg::CurWidth-1:0] current_4_i,
  input  logic [icar_pkg::CurWidth-1:0] current_5_i,
  input  logic [icar_pkg::CurWidth-1:0] current_6_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    tx_byte_o
);
  import icar_pkg::*;

  localparam int unsigned ChW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned MemW    = SumWidth + COUNT_WIDTH;
  localparam logic [4:0]  SendLen = 5'(2 * CHANNELS);

  state_e state_q, state_d;
  logic [ChW-1:0] ch_q, ch_d;
  logic [7:0]     cmd_q, cmd_d, mask_q, mask_d, tx_q, tx_d;
  logic [4:0]     pos_q, pos_d;
  logic [CHANNELS-1:0] acc_vld_q, acc_vld_d, avg_vld_q, avg_vld_d;
  logic [CurWidth-1:0] cur_q [CurFields];
  logic                out_ok_q;
  logic                fetch_d;

  // Accumulator memory holds {sum, count}; average memory holds averages.
  logic [MemW-1:0]     acc_mem [CHANNELS];
  logic [AvgWidth-1:0] avg_mem [CHANNELS];
  logic [MemW-1:0]     acc_rd_q;
  logic [AvgWidth-1:0] avg_rd_q;
  logic                acc_we, avg_we;
  logic [ChW-1:0]      acc_ra, avg_ra;
  logic [MemW-1:0]     acc_wd;

  div_req_t            div_req;
  div_stat_t           div_stat;
  logic [AvgWidth-1:0] quotient;

  logic [SumWidth-1:0]    acc_sum;
  logic [COUNT_WIDTH-1:0] acc_cnt;
  logic [CurWidth-1:0]    cur_sel;
  logic [ChW-1:0]         pos_ch;
  logic [AvgWidth-1:0]    avg_word;

  assign acc_sum = acc_vld_q[ch_q] ? acc_rd_q[MemW-1:COUNT_WIDTH] : '0;
  assign acc_cnt = acc_vld_q[ch_q] ? acc_rd_q[COUNT_WIDTH-1:0] : '0;
  assign cur_sel = (32'(ch_q) < CurFields) ? cur_q[3'(ch_q)] : '0;
  assign pos_ch  = ChW'(pos_q[4:1]);
  assign avg_word = avg_vld_q[pos_ch] ? avg_rd_q : '0;

  // Synchronous memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (acc_we) acc_mem[ch_q] <= acc_wd;
    acc_rd_q <= acc_mem[acc_ra];
    if (avg_we) avg_mem[ch_q] <= quotient;
    avg_rd_q <= avg_mem[avg_ra];
  end

  // Capture the sample fields with the request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cur_q[0] <= current_0_i;
      cur_q[1] <= current_1_i;
      cur_q[2] <= current_2_i;
      cur_q[3] <= current_3_i;
      cur_q[4] <= current_4_i;
      cur_q[5] <= current_5_i;
      cur_q[6] <= current_6_i;
    end
  end

  icar_divider #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
    .clk_i,
    .rst_ni,
    .req_i      (div_req),
    .dividend_i (acc_sum),
    .divisor_i  (acc_cnt),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // Sequencer for all request kinds.
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    cmd_d     = cmd_q;
    mask_d    = mask_q;
    pos_d     = pos_q;
    tx_d      = tx_q;
    acc_vld_d = acc_vld_q;
    avg_vld_d = avg_vld_q;
    acc_we    = 1'b0;
    avg_we    = 1'b0;
    acc_wd    = '0;
    acc_ra    = ch_q;
    avg_ra    = pos_ch;
    fetch_d   = 1'b0;
    div_req.start = 1'b0;
    in_ready_o = (state_q == StIdle);
    unique case (state_q)
      StIdle: begin
        ch_d   = '0;
        acc_ra = '0;
        if (in_valid_i) begin
          unique case (event_kind_i)
            EvSample: state_d = StAccRd;
            EvAddr: begin
              pos_d = '0;
              if (read_not_write_i) begin
                state_d = (cmd_q == CmdReadCurrent) ? StDivRd : StTx;
              end
            end
            EvRx: begin
              if (pos_q == '0) cmd_d = rx_byte_i;
              else if (pos_q == 5'd1 && cmd_q == CmdReadCurrent) mask_d = rx_byte_i;
              if (pos_q < PosMax) pos_d = pos_q + 5'd1;
            end
            default: state_d = StTx;
          endcase
        end
      end
      StAccRd: state_d = StAccWr;
      StAccWr: begin
        acc_we = 1'b1;
        acc_wd = {acc_sum + SumWidth'(cur_sel), acc_cnt + 1'b1};
        acc_vld_d[ch_q] = 1'b1;
        if (32'(ch_q) == CHANNELS - 1) begin
          state_d = StIdle;
        end else begin
          ch_d    = ch_q + 1'b1;
          acc_ra  = ch_q + 1'b1;
          state_d = StAccRd;
        end
      end
      StDivRd: begin
        div_req.start = 1'b1;
        state_d = StDivRun;
      end
      StDivRun: if (div_stat.done) state_d = StDivWr;
      StDivWr: begin
        avg_we = 1'b1;
        avg_vld_d[ch_q] = 1'b1;
        acc_vld_d[ch_q] = 1'b0;
        if (32'(ch_q) == CHANNELS - 1) begin
          state_d = StTx;
        end else begin
          ch_d    = ch_q + 1'b1;
          acc_ra  = ch_q + 1'b1;
          state_d = StDivRd;
        end
      end
      StTx: begin
        // For read-current, skip masked-off channels one word per cycle, then read the word.
        if (cmd_q == CmdMagic) begin
          tx_d = MagicByte;
          state_d = StOut;
        end else if (cmd_q != CmdReadCurrent) begin
          tx_d = '0;
          state_d = StOut;
        end else if (pos_q >= SendLen) begin
          tx_d = '0;
          state_d = StOut;
        end else if (!mask_q[pos_q[3:1]]) begin
          pos_d = pos_q + 5'd2;
          avg_ra = ChW'(pos_d[4:1]);
        end else begin
          state_d = StOut;
          fetch_d = 1'b1;
        end
      end
      StOut: begin
        // Pick the byte out of the word read in the transmit step.
        if (!out_ok_q) begin
          tx_d  = pos_q[0] ? avg_word[15:8] : avg_word[7:0];
          pos_d = pos_q + 5'd1;
        end else if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The word read for a transmit is held in the first cycle of StOut.
  assign out_valid_o = (state_q == StOut) && out_ok_q;
  assign tx_byte_o   = tx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ch_q      <= '0;
      cmd_q     <= '0;
      mask_q    <= '0;
      pos_q     <= '0;
      tx_q      <= '0;
      acc_vld_q <= '0;
      avg_vld_q <= '0;
      out_ok_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      cmd_q     <= cmd_d;
      mask_q    <= mask_d;
      pos_q     <= pos_d;
      tx_q      <= tx_d;
      acc_vld_q <= acc_vld_d;
      avg_vld_q <= avg_vld_d;
      // The byte is final unless an average byte still has to be picked.
      out_ok_q  <= (state_d == StOut) && !fetch_d;
    end
  end

  // A result is only offered while the sequencer waits in the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut)
    else $error("result outside output state");

  // New requests are refused while a division runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> !in_ready_o)
    else $error("request accepted during division");

  // The divider is only started from the read step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> state_q == StDivRun)
    else $error("divider start out of sequence");

endmodule
